>>> src/polygon_ear_clip_triangulator_defines.svh
// ----------------------------------------------------------------------------
// Polygon ear-clip triangulator assertion macros
// Shared property forms for the checker of the triangulator's ports.
// ----------------------------------------------------------------------------
`ifndef POLYGON_EAR_CLIP_TRIANGULATOR_DEFINES_SVH
`define POLYGON_EAR_CLIP_TRIANGULATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PECT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PECT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pect_pkg.sv
// ----------------------------------------------------------------------------
// Polygon ear-clip triangulator package
// Shared types and constants of the triangulator and its checker.
// ----------------------------------------------------------------------------
package pect_pkg;

  // Width of a corner index word on the result channel.
  localparam int CORNER_W = 6;
  localparam int FAULT_W  = 2;

  // Fault codes carried with every result word.
  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE   = 2'd0,
    FAULT_FEW    = 2'd1,
    FAULT_NO_EAR = 2'd2
  } fault_t;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_START,
    ST_FEW,
    ST_C_RI,
    ST_C_RJ,
    ST_C_RK,
    ST_C_W0,
    ST_C_W1,
    ST_MUL,
    ST_CMP,
    ST_T_RL,
    ST_T_RV,
    ST_T_LD,
    ST_EAR,
    ST_SH_RD,
    ST_SH_WR,
    ST_NEXT,
    ST_NOEAR,
    ST_F0,
    ST_F1,
    ST_F2,
    ST_F3,
    ST_FEMIT
  } state_t;

endpackage

>>> src/polygon_ear_clip_triangulator.sv
// Vertices stream in one word per cycle and are written into a vertex memory
// and an index list memory. The word marked last_vertex closes the polygon;
// the input then stalls while a sequencer clips ears out of the list and
// emits one triangle word per ear, ending with the last three corners (or a
// single fault word for under three vertices or when no ear is found). Each
// candidate corner is read and given a turn test, then each remaining vertex
// is tested against it (one multiplier pass per triangle edge), and each
// clipped ear moves the later list entries down, one read and one write per
// entry. The single read port of each memory and the shared multiplier keep
// these steps in sequence. The input is taken again in the cycle after the
// final word is issued.
// ----------------------------------------------------------------------------
// Polygon ear-clip triangulator
// Loads a clockwise simple polygon and triangulates it by ear clipping.
// ----------------------------------------------------------------------------
module polygon_ear_clip_triangulator #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [COORD_BITS-1:0]      in_vert_x,
  input  logic signed [COORD_BITS-1:0]      in_vert_y,
  input  logic                              in_last_vertex,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [pect_pkg::CORNER_W-1:0]     out_corner_a,
  output logic [pect_pkg::CORNER_W-1:0]     out_corner_b,
  output logic [pect_pkg::CORNER_W-1:0]     out_corner_c,
  output logic                              out_last_triangle,
  output logic [pect_pkg::FAULT_W-1:0]      out_fault
);
  import pect_pkg::*;

  localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int CB     = COORD_BITS;
  localparam int PROD_W = 2 * CB + 2;

  // Advance a list position by one, wrapping at the list size.
  function automatic logic [CNT_W-1:0] wrap_inc(input logic [CNT_W-1:0] p,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] q;
    q = p + CNT_W'(1);
    return (q == lim) ? '0 : q;
  endfunction

  state_t state_r, state_nxt;

  // Memories and their ports.
  logic [2*CB-1:0]  vstore [MAX_VERTICES];
  logic [IDX_W-1:0] wlist  [MAX_VERTICES];
  logic [IDX_W-1:0] vs_raddr, wl_raddr, wl_waddr;
  logic [IDX_W-1:0] wl_wdata;
  logic             wl_we;
  logic [2*CB-1:0]  vs_rdata_r;
  logic [IDX_W-1:0] wl_rdata_r;

  // Control registers.
  logic [CNT_W-1:0] cnt_r, ws_r, i_r, j_r, k_r, pos_r, rem_r, d_r;
  logic             clipped_r, testing_r;
  logic [1:0]       edge_r;

  // Datapath registers.
  logic [IDX_W-1:0]       i0_r, i1_r, i2_r;
  logic signed [CB-1:0]   p0x_r, p0y_r, p1x_r, p1y_r, p2x_r, p2y_r, vx_r, vy_r;
  logic signed [PROD_W-1:0] prod_a_r, prod_b_r;

  // Handshake and emit signals.
  logic       in_fire, emit_go, emit_req, emit_fire, neg;
  logic [CORNER_W-1:0] em_a, em_b, em_c;
  logic       em_last;
  fault_t     em_fault;

  // Multiplier operands.
  logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
  logic signed [CB:0]   dbx, dby, dcx, dcy;

  logic                 out_valid_r;
  logic [CORNER_W-1:0]  out_a_r, out_b_r, out_c_r;
  logic                 out_last_r;
  fault_t               out_fault_r;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_fire   = in_valid && !in_stall;
  assign emit_go   = !out_valid_r || !out_stall;
  assign emit_fire = emit_req && emit_go;
  assign neg       = (prod_a_r < prod_b_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:  if (in_fire && in_last_vertex) state_nxt = ST_START;
      ST_START: begin
        if (cnt_r < CNT_W'(3)) state_nxt = ST_FEW;
        else if (cnt_r == CNT_W'(3)) state_nxt = ST_F0;
        else state_nxt = ST_C_RI;
      end
      ST_FEW:   if (emit_go) state_nxt = ST_LOAD;
      ST_C_RI:  state_nxt = ST_C_RJ;
      ST_C_RJ:  state_nxt = ST_C_RK;
      ST_C_RK:  state_nxt = ST_C_W0;
      ST_C_W0:  state_nxt = ST_C_W1;
      ST_C_W1:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (!testing_r) state_nxt = neg ? ST_T_RL : ST_NEXT;
        else if (!neg) state_nxt = (rem_r == CNT_W'(1)) ? ST_EAR : ST_T_RL;
        else state_nxt = (edge_r == 2'd2) ? ST_NEXT : ST_MUL;
      end
      ST_T_RL:  state_nxt = ST_T_RV;
      ST_T_RV:  state_nxt = ST_T_LD;
      ST_T_LD:  state_nxt = ST_MUL;
      ST_EAR: begin
        if (emit_go) state_nxt = (j_r < ws_r - CNT_W'(1)) ? ST_SH_RD : ST_NEXT;
      end
      ST_SH_RD: state_nxt = ST_SH_WR;
      ST_SH_WR: state_nxt = (d_r + CNT_W'(1) < ws_r) ? ST_SH_RD : ST_NEXT;
      ST_NEXT: begin
        if (ws_r <= CNT_W'(3)) state_nxt = ST_F0;
        else if (i_r + CNT_W'(1) < ws_r || clipped_r) state_nxt = ST_C_RI;
        else state_nxt = ST_NOEAR;
      end
      ST_NOEAR: if (emit_go) state_nxt = ST_LOAD;
      ST_F0:    state_nxt = ST_F1;
      ST_F1:    state_nxt = ST_F2;
      ST_F2:    state_nxt = ST_F3;
      ST_F3:    state_nxt = ST_FEMIT;
      ST_FEMIT: if (emit_go) state_nxt = ST_LOAD;
      default:  state_nxt = ST_LOAD;
    endcase
  end

  // Memory addresses, list writes and the emitted word.
  always_comb begin
    vs_raddr = '0;
    wl_raddr = '0;
    wl_we    = 1'b0;
    wl_waddr = cnt_r[IDX_W-1:0];
    wl_wdata = cnt_r[IDX_W-1:0];
    emit_req = 1'b0;
    em_a     = CORNER_W'(i0_r);
    em_b     = CORNER_W'(i1_r);
    em_c     = CORNER_W'(i2_r);
    em_last  = 1'b0;
    em_fault = FAULT_NONE;
    case (state_r)
      ST_LOAD:  wl_we = in_fire && (cnt_r < CNT_W'(MAX_VERTICES));
      ST_C_RI:  wl_raddr = i_r[IDX_W-1:0];
      ST_C_RJ: begin
        wl_raddr = j_r[IDX_W-1:0];
        vs_raddr = wl_rdata_r;
      end
      ST_C_RK: begin
        wl_raddr = k_r[IDX_W-1:0];
        vs_raddr = wl_rdata_r;
      end
      ST_C_W0:  vs_raddr = wl_rdata_r;
      ST_T_RL:  wl_raddr = pos_r[IDX_W-1:0];
      ST_T_RV:  vs_raddr = wl_rdata_r;
      ST_EAR:   emit_req = 1'b1;
      ST_SH_RD: wl_raddr = d_r[IDX_W-1:0] + IDX_W'(1);
      ST_SH_WR: begin
        wl_we    = 1'b1;
        wl_waddr = d_r[IDX_W-1:0];
        wl_wdata = wl_rdata_r;
      end
      ST_FEW, ST_NOEAR: begin
        emit_req = 1'b1;
        em_a     = '0;
        em_b     = '0;
        em_c     = '0;
        em_last  = 1'b1;
        em_fault = (state_r == ST_FEW) ? FAULT_FEW : FAULT_NO_EAR;
      end
      ST_F0:    wl_raddr = '0;
      ST_F1:    wl_raddr = IDX_W'(1);
      ST_F2:    wl_raddr = IDX_W'(2);
      ST_FEMIT: begin
        emit_req = 1'b1;
        em_last  = 1'b1;
      end
      default: ;
    endcase
  end

  // Operand selection for the shared cross-product unit.
  always_comb begin
    ax = p0x_r; ay = p0y_r; bx = p1x_r; by = p1y_r; cx = p2x_r; cy = p2y_r;
    if (testing_r) begin
      cx = vx_r;
      cy = vy_r;
      case (edge_r)
        2'd1: begin
          ax = p1x_r; ay = p1y_r; bx = p2x_r; by = p2y_r;
        end
        2'd2: begin
          ax = p2x_r; ay = p2y_r; bx = p0x_r; by = p0y_r;
        end
        default: ;
      endcase
    end
    dbx = {bx[CB-1], bx} - {ax[CB-1], ax};
    dby = {by[CB-1], by} - {ay[CB-1], ay};
    dcx = {cx[CB-1], cx} - {ax[CB-1], ax};
    dcy = {cy[CB-1], cy} - {ay[CB-1], ay};
  end

  // Vertex memory: written while loading, read one word per cycle.
  always_ff @(posedge clk) begin
    if (in_fire && (cnt_r < CNT_W'(MAX_VERTICES))) begin
      vstore[cnt_r[IDX_W-1:0]] <= {in_vert_x, in_vert_y};
    end
    vs_rdata_r <= vstore[vs_raddr];
  end

  // Index list memory: filled with the load order, compacted on each ear.
  always_ff @(posedge clk) begin
    if (wl_we) begin
      wlist[wl_waddr] <= wl_wdata;
    end
    wl_rdata_r <= wlist[wl_raddr];
  end

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      ws_r      <= '0;
      i_r       <= '0;
      clipped_r <= 1'b0;
      testing_r <= 1'b0;
      edge_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: begin
          if (in_fire && (cnt_r < CNT_W'(MAX_VERTICES))) cnt_r <= cnt_r + CNT_W'(1);
        end
        ST_START: begin
          ws_r      <= cnt_r;
          i_r       <= '0;
          clipped_r <= 1'b0;
          if (cnt_r >= CNT_W'(3)) cnt_r <= '0;
        end
        ST_FEW: if (emit_go) cnt_r <= '0;
        ST_C_RI: testing_r <= 1'b0;
        ST_CMP: begin
          if (!testing_r) begin
            if (neg) testing_r <= 1'b1;
          end else if (neg && edge_r != 2'd2) begin
            edge_r <= edge_r + 2'd1;
          end
        end
        ST_T_LD: edge_r <= '0;
        ST_EAR: begin
          if (emit_go) begin
            ws_r      <= ws_r - CNT_W'(1);
            clipped_r <= 1'b1;
          end
        end
        ST_NEXT: begin
          if (i_r + CNT_W'(1) < ws_r) begin
            i_r <= i_r + CNT_W'(1);
          end else begin
            i_r       <= '0;
            clipped_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sequencer datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_C_RI: begin
        j_r <= wrap_inc(i_r, ws_r);
        k_r <= wrap_inc(wrap_inc(i_r, ws_r), ws_r);
      end
      ST_C_RJ: i0_r <= wl_rdata_r;
      ST_C_RK: begin
        i1_r <= wl_rdata_r;
        {p0x_r, p0y_r} <= vs_rdata_r;
      end
      ST_C_W0: begin
        i2_r <= wl_rdata_r;
        {p1x_r, p1y_r} <= vs_rdata_r;
      end
      ST_C_W1: {p2x_r, p2y_r} <= vs_rdata_r;
      ST_MUL: begin
        prod_a_r <= dbx * dcy;
        prod_b_r <= dby * dcx;
      end
      ST_CMP: begin
        if (!testing_r) begin
          rem_r <= ws_r - CNT_W'(3);
          pos_r <= wrap_inc(k_r, ws_r);
        end else if (!neg) begin
          rem_r <= rem_r - CNT_W'(1);
          pos_r <= wrap_inc(pos_r, ws_r);
        end
      end
      ST_T_LD: {vx_r, vy_r} <= vs_rdata_r;
      ST_EAR:  d_r <= j_r;
      ST_SH_WR: d_r <= d_r + CNT_W'(1);
      ST_F1: i0_r <= wl_rdata_r;
      ST_F2: i1_r <= wl_rdata_r;
      ST_F3: i2_r <= wl_rdata_r;
      default: ;
    endcase
  end

  // Output register: holds a word until the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_a_r     <= em_a;
      out_b_r     <= em_b;
      out_c_r     <= em_c;
      out_last_r  <= em_last;
      out_fault_r <= em_fault;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_corner_a      = out_a_r;
  assign out_corner_b      = out_b_r;
  assign out_corner_c      = out_c_r;
  assign out_last_triangle = out_last_r;
  assign out_fault         = out_fault_r;

endmodule

>>> src/pect_checker.sv
// ----------------------------------------------------------------------------
// Polygon ear-clip triangulator checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "polygon_ear_clip_triangulator_defines.svh"

module pect_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pect_pkg::CORNER_W-1:0] out_corner_a,
  input logic [pect_pkg::CORNER_W-1:0] out_corner_b,
  input logic [pect_pkg::CORNER_W-1:0] out_corner_c,
  input logic                          out_last_triangle,
  input logic [pect_pkg::FAULT_W-1:0]  out_fault
);
  import pect_pkg::*;

  // A faulty word always closes the polygon.
  `PECT_ASSERT_IMP(a_fault_last, out_valid && out_fault != FAULT_NONE, out_last_triangle, "fault word without last_triangle")

  // A faulty word carries no corners.
  `PECT_ASSERT_IMP(a_fault_zero, out_valid && out_fault != FAULT_NONE, out_corner_a == '0 && out_corner_b == '0 && out_corner_c == '0, "fault word with corners")

  // A good triangle has three distinct corners.
  `PECT_ASSERT_IMP(a_distinct, out_valid && out_fault == FAULT_NONE, out_corner_a != out_corner_b && out_corner_b != out_corner_c && out_corner_a != out_corner_c, "repeated corner")

  // A stalled result word stays valid, with its middle corner and fault code held.
  `PECT_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_corner_b) && $stable(out_fault), "stalled word changed")

endmodule

bind polygon_ear_clip_triangulator pect_checker u_pect_checker (.*);
